// ===== rtl/thr_pkg.sv =====
// timestamped history ring: shared widths, codes, result type and helper functions
// no dependencies; imported by thr_core and the top level

package thr_pkg;

  localparam int unsigned HistDepth = 16;
  localparam int unsigned StateBits = 32;

  localparam int unsigned PtrW    = $clog2(HistDepth);
  localparam int unsigned CntW    = $clog2(HistDepth + 1);
  localparam int unsigned TimeW   = 31;
  localparam int unsigned OutW    = 32;
  localparam int unsigned EntryW  = TimeW + StateBits;

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef struct packed {
    status_e            status;
    logic [TimeW-1:0]   last_time;
    logic [OutW-1:0]    current_state;
    logic [OutW-1:0]    found_state;
  } result_t;

  function automatic logic [PtrW-1:0] ptr_dec(input logic [PtrW-1:0] p);
    return (p == '0) ? PtrW'(HistDepth - 1) : p - PtrW'(1);
  endfunction

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(HistDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  function automatic logic [StateBits-1:0] fit_state(input logic [OutW-1:0] s);
    logic [63:0] w;
    w = 64'(s);
    return w[StateBits-1:0];
  endfunction

  function automatic logic [OutW-1:0] out_state(input logic [StateBits-1:0] s);
    logic [63:0] w;
    w = 64'(s);
    return w[OutW-1:0];
  endfunction

endpackage

// ===== rtl/thr_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies

module thr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/thr_core.sv =====
// timestamped history ring: record/lookup sequencer around the entry ram
// depends on thr_pkg and thr_ram

module thr_core
  import thr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cmd_e              in_cmd_i,
  input  logic [OutW-1:0]   in_state_i,
  input  logic [TimeW-1:0]  in_time_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output result_t           res_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } walk_state_e;

  walk_state_e           state_q, state_d;
  logic [PtrW-1:0]       wp_q, wp_d;
  logic [PtrW-1:0]       last_q, last_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       fill_q, fill_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [TimeW-1:0]      qtime_q, qtime_d;
  logic [StateBits-1:0]  prev_q, prev_d;
  logic [StateBits-1:0]  head_state_q, head_state_d;
  logic [TimeW-1:0]      head_time_q, head_time_d;
  result_t               res_q, res_d;
  logic                  res_valid_q, res_valid_d;

  logic                  accept;
  logic                  we;
  logic [PtrW-1:0]       waddr;
  logic [EntryW-1:0]     wdata;
  logic [PtrW-1:0]       raddr;
  logic [EntryW-1:0]     rdata;
  logic [StateBits-1:0]  st_in;
  logic [StateBits-1:0]  rd_state;
  logic [TimeW-1:0]      rd_time;

  // records and lookups never overlap, so the ram needs no forwarding
  thr_ram #(
    .Width (EntryW),
    .Depth (HistDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE) && !res_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign st_in       = fit_state(in_state_i);
  assign rd_state    = rdata[StateBits-1:0];
  assign rd_time     = rdata[EntryW-1:StateBits];
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d      = state_q;
    wp_d         = wp_q;
    last_d       = last_q;
    rd_ptr_d     = rd_ptr_q;
    fill_d       = fill_q;
    cnt_d        = cnt_q;
    qtime_d      = qtime_q;
    prev_d       = prev_q;
    head_state_d = head_state_q;
    head_time_d  = head_time_q;
    res_d        = res_q;
    res_valid_d  = res_valid_q && !res_ready_i;
    we           = 1'b0;
    waddr        = wp_q;
    wdata        = {in_time_i, st_in};
    raddr        = ptr_dec(last_q);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd_i == CMD_RECORD) begin
            res_valid_d = 1'b1;
            if (fill_q == '0 || in_time_i > head_time_q) begin
              // append, dropping the oldest entry when full
              we           = 1'b1;
              wp_d         = ptr_inc(wp_q);
              last_d       = wp_q;
              fill_d       = (fill_q == CntW'(HistDepth)) ? fill_q : fill_q + CntW'(1);
              head_state_d = st_in;
              head_time_d  = in_time_i;
              res_d        = '{ST_OK, in_time_i, out_state(st_in), out_state(st_in)};
            end else if (in_time_i == head_time_q) begin
              // same time: overwrite newest state in place
              we           = 1'b1;
              waddr        = last_q;
              wdata        = {head_time_q, st_in};
              head_state_d = st_in;
              res_d        = '{ST_OK, head_time_q, out_state(st_in), out_state(st_in)};
            end else begin
              res_d = '{ST_REJECT, head_time_q, out_state(head_state_q),
                        out_state(head_state_q)};
            end
          end else begin
            if (fill_q == '0) begin
              res_valid_d = 1'b1;
              res_d       = '{ST_EMPTY, '0, '0, '0};
            end else if (fill_q == CntW'(1)) begin
              res_valid_d = 1'b1;
              res_d       = '{ST_OK, head_time_q, out_state(head_state_q),
                              out_state(head_state_q)};
            end else begin
              rd_ptr_d = ptr_dec(last_q);
              cnt_d    = CntW'(2);
              qtime_d  = in_time_i;
              prev_d   = head_state_q;
              state_d  = S_WALK;
            end
          end
        end
      end
      S_WALK: begin
        if (rd_time < qtime_q) begin
          res_valid_d = 1'b1;
          res_d       = '{ST_OK, head_time_q, out_state(head_state_q), out_state(prev_q)};
          state_d     = S_IDLE;
        end else if (cnt_q == fill_q) begin
          res_valid_d = 1'b1;
          res_d       = '{ST_OK, head_time_q, out_state(head_state_q), out_state(rd_state)};
          state_d     = S_IDLE;
        end else begin
          prev_d   = rd_state;
          raddr    = ptr_dec(rd_ptr_q);
          rd_ptr_d = ptr_dec(rd_ptr_q);
          cnt_d    = cnt_q + CntW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      last_q      <= PtrW'(HistDepth - 1);
      fill_q      <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      last_q      <= last_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q     <= rd_ptr_d;
    qtime_q      <= qtime_d;
    prev_q       <= prev_d;
    head_state_q <= head_state_d;
    head_time_q  <= head_time_d;
    res_q        <= res_d;
  end

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(HistDepth))
    else $error("fill count above ring depth");

  a_walk_no_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> !res_valid_q)
    else $error("walk running with a result still pending");

  a_walk_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (cnt_q >= CntW'(2) && cnt_q <= fill_q))
    else $error("walk index outside stored entries");

  a_last_ptr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q == ptr_dec(wp_q))
    else $error("newest slot pointer out of step with write pointer");

endmodule

// ===== rtl/timestamped_history_ring_unit.sv =====
// timestamped history ring: top level with stream ports and output register
// depends on thr_pkg and thr_core
//
// channel   dir  tdata                                         tuser
// s_axis    in   new_state[31:0], time_value[62:32], pad[63]   command[0]
// m_axis    out  found_state[31:0], current_state[63:32],      status[1:0]
//                last_change_time[94:64], pad[95]
//
// record, and lookup on a ring holding zero or one entry: answered from the head registers
// other lookups: walk back through older entries (up to 15), one ram read per cycle
// reset leaves the ring empty; the entry ram is not cleared
// input stalls while a walk runs or a result waits in the holding stage;
// a result waits there only while the output register is full and not taken

module timestamped_history_ring_unit
  import thr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // new_state, time_value, zero pad
  input  logic [0:0]  s_axis_tuser_i,   // command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o,   // found_state, current_state, last_change_time, pad
  output logic [1:0]  m_axis_tuser_o    // status
);

  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_q;
  logic    out_valid_q;

  thr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_cmd_i    (cmd_e'(s_axis_tuser_i[0])),
    .in_state_i  (s_axis_tdata_i[31:0]),
    .in_time_i   (s_axis_tdata_i[62:32]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.last_time, out_q.current_state, out_q.found_state};
  assign m_axis_tuser_o  = out_q.status;

endmodule
